### rtl/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg: shared types for the occupancy cube inflation block
// Word kinds, register indexes, controller states, and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package occ_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_CLEAR   = 2'd1,
      KIND_INFLATE = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_S_POS_STEPS   = 3'd0,
      REG_S_NEG_STEPS   = 3'd1,
      REG_D_POS_STEPS   = 3'd2,
      REG_D_NEG_STEPS   = 3'd3,
      REG_T_POS_STEPS   = 3'd4,
      REG_MAX_TIME_SPAN = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      SIDE_S_POS = 3'd0,
      SIDE_S_NEG = 3'd1,
      SIDE_D_POS = 3'd2,
      SIDE_D_NEG = 3'd3,
      SIDE_T_POS = 3'd4
   } side_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_WR_RD,
      ST_WR_WR,
      ST_CLR,
      ST_BOX_RD,
      ST_BOX_CHK,
      ST_SIDE,
      ST_STEP,
      ST_PLANE_RD,
      ST_PLANE_CHK,
      ST_NEXT,
      ST_ROUND_END,
      ST_T_END,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [6:0] s_pos_steps;
      logic [6:0] s_neg_steps;
      logic [4:0] d_pos_steps;
      logic [4:0] d_neg_steps;
      logic [5:0] t_pos_steps;
      logic [5:0] max_time_span;
   } cfg_type;

   typedef struct packed {
      logic load;        // capture the input word
      logic rd;          // read the word under the scan position
      logic step;        // advance the scan position
      logic wr;          // write back the modified word
      logic clr;         // clear one word of the map
      logic setup;       // set the scan region to the next plane of the side
      logic accept;      // move the side's bound onto the plane
      logic done;        // mark the side finished
      logic next_side;   // advance to the next s or d side, restart the step count
      logic round_end;   // apply s limits, start next round or time growth
      logic fail;        // seed cube is blocked
      logic result;      // load the output register
   } cmd_type;

   typedef struct packed {
      logic     req_wr_ok;
      logic     busy;
      logic     scan_last;
      logic     side_skip;
      logic     steps_zero;
      logic     steps_used;
      logic     at_edge;
      side_type side;
      logic     round_all;
      logic     t_flag;
      logic     span_full;
      logic     clear_last;
      logic     out_blocked;
   } status_type;

endpackage

### rtl/occ_csr.sv
// ----------------------------------------------------------------------------
// occ_csr: configuration registers
// Holds the step counts and the time span limit behind a simple bus port.
// ----------------------------------------------------------------------------
module occ_csr
   import occ_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.s_pos_steps   <= 7'd1;
         cfg_ff.s_neg_steps   <= 7'd1;
         cfg_ff.d_pos_steps   <= 5'd1;
         cfg_ff.d_neg_steps   <= 5'd1;
         cfg_ff.t_pos_steps   <= 6'd1;
         cfg_ff.max_time_span <= 6'd8;
      end else if (wr_en) begin
         case (index)
            REG_S_POS_STEPS:   cfg_ff.s_pos_steps   <= pwdata[6:0];
            REG_S_NEG_STEPS:   cfg_ff.s_neg_steps   <= pwdata[6:0];
            REG_D_POS_STEPS:   cfg_ff.d_pos_steps   <= pwdata[4:0];
            REG_D_NEG_STEPS:   cfg_ff.d_neg_steps   <= pwdata[4:0];
            REG_T_POS_STEPS:   cfg_ff.t_pos_steps   <= pwdata[5:0];
            REG_MAX_TIME_SPAN: cfg_ff.max_time_span <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_S_POS_STEPS:   prdata = 32'(cfg_ff.s_pos_steps);
         REG_S_NEG_STEPS:   prdata = 32'(cfg_ff.s_neg_steps);
         REG_D_POS_STEPS:   prdata = 32'(cfg_ff.d_pos_steps);
         REG_D_NEG_STEPS:   prdata = 32'(cfg_ff.d_neg_steps);
         REG_T_POS_STEPS:   prdata = 32'(cfg_ff.t_pos_steps);
         REG_MAX_TIME_SPAN: prdata = 32'(cfg_ff.max_time_span);
         default:           prdata = 32'd0;
      endcase
   end

endmodule

### rtl/occ_ctrl.sv
// ----------------------------------------------------------------------------
// occ_ctrl: sequencing state machine
// Walks the write, clear and inflate sequences and commands the datapath.
// ----------------------------------------------------------------------------
module occ_ctrl
   import occ_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   input  status_type st,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   kind_type  kind;

   assign kind = kind_type'(req_kind);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_CLR: if (st.clear_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               case (kind)
                  KIND_WRITE:   state_in = st.req_wr_ok ? ST_WR_RD : ST_DONE;
                  KIND_CLEAR:   state_in = ST_CLR;
                  KIND_INFLATE: state_in = ST_BOX_RD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_WR_RD:  state_in = ST_WR_WR;
         ST_WR_WR:  state_in = ST_DONE;
         ST_CLR:    if (st.clear_last) state_in = ST_DONE;
         ST_BOX_RD: state_in = ST_BOX_CHK;
         ST_BOX_CHK: begin
            if (st.busy)           state_in = ST_DONE;
            else if (st.scan_last) state_in = ST_SIDE;
            else                   state_in = ST_BOX_RD;
         end
         ST_SIDE: begin
            if (st.side_skip || st.steps_zero) state_in = ST_NEXT;
            else                               state_in = ST_STEP;
         end
         ST_STEP: begin
            if (st.steps_used || st.at_edge) state_in = ST_NEXT;
            else                             state_in = ST_PLANE_RD;
         end
         ST_PLANE_RD: state_in = ST_PLANE_CHK;
         ST_PLANE_CHK: begin
            if (st.busy)           state_in = ST_NEXT;
            else if (st.scan_last) state_in = ST_STEP;
            else                   state_in = ST_PLANE_RD;
         end
         ST_NEXT: begin
            case (st.side)
               SIDE_D_NEG: state_in = ST_ROUND_END;
               SIDE_T_POS: state_in = ST_T_END;
               default:    state_in = ST_SIDE;
            endcase
         end
         ST_ROUND_END: state_in = ST_SIDE;
         ST_T_END: begin
            if (st.t_flag || st.span_full) state_in = ST_DONE;
            else                           state_in = ST_SIDE;
         end
         ST_DONE: if (!st.out_blocked) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_INIT_CLR: cmd.clr  = 1'b1;
         ST_IDLE:     cmd.load = req_valid;
         ST_WR_RD:    cmd.rd   = 1'b1;
         ST_WR_WR:    cmd.wr   = 1'b1;
         ST_CLR:      cmd.clr  = 1'b1;
         ST_BOX_RD:   cmd.rd   = 1'b1;
         ST_BOX_CHK: begin
            cmd.fail = st.busy;
            cmd.step = !st.busy && !st.scan_last;
         end
         ST_SIDE:     cmd.done = !st.side_skip && st.steps_zero;
         ST_STEP: begin
            cmd.done  = !st.steps_used && st.at_edge;
            cmd.setup = !st.steps_used && !st.at_edge;
         end
         ST_PLANE_RD: cmd.rd = 1'b1;
         ST_PLANE_CHK: begin
            cmd.done   = st.busy;
            cmd.accept = !st.busy && st.scan_last;
            cmd.step   = !st.busy && !st.scan_last;
         end
         ST_NEXT:      cmd.next_side = 1'b1;
         ST_ROUND_END: cmd.round_end = 1'b1;
         ST_DONE:      cmd.result    = !st.out_blocked;
         default: ;
      endcase
   end

endmodule

### rtl/occ_dp.sv
// ----------------------------------------------------------------------------
// occ_dp: occupancy map and cube datapath
// Holds the bitmap memory, the cube bounds, the scan region and position,
// the side bookkeeping and the output register.
// ----------------------------------------------------------------------------
module occ_dp
   import occ_pkg::*;
#(
   parameter int GRID_S = 128,
   parameter int GRID_D = 32,
   parameter int GRID_T = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  cfg_type     cfg,
   input  logic [1:0]  req_kind,
   input  logic [6:0]  req_first_s,
   input  logic [4:0]  req_first_d,
   input  logic [5:0]  req_first_t,
   input  logic        req_cell_occupied,
   input  logic [6:0]  req_second_s,
   input  logic [4:0]  req_second_d,
   input  logic [5:0]  req_second_t,
   input  logic [6:0]  req_s_upper_limit,
   input  logic [6:0]  req_s_lower_limit,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic        rsp_initial_free,
   output logic [6:0]  rsp_low_s,
   output logic [6:0]  rsp_high_s,
   output logic [4:0]  rsp_low_d,
   output logic [4:0]  rsp_high_d,
   output logic [5:0]  rsp_low_t,
   output logic [5:0]  rsp_high_t,
   output status_type  st
);

   localparam int SW    = $clog2(GRID_S);
   localparam int DW    = $clog2(GRID_D);
   localparam int TW    = $clog2(GRID_T);
   localparam int AW    = SW + DW + TW;
   localparam int LOGW  = (AW > 5) ? 5 : AW - 1;
   localparam int WORDW = 1 << LOGW;
   localparam int DAW   = AW - LOGW;
   localparam int DEPTH = 1 << DAW;

   localparam logic [SW-1:0] S_MAX = SW'(GRID_S - 1);
   localparam logic [DW-1:0] D_MAX = DW'(GRID_D - 1);
   localparam logic [TW-1:0] T_MAX = TW'(GRID_T - 1);

   logic [WORDW-1:0] mem [DEPTH];
   logic [WORDW-1:0] rd_ff;
   logic [WORDW-1:0] wr_word;
   logic [DAW-1:0]   clr_ff;

   logic [SW-1:0] lo_s_ff, hi_s_ff, rlo_s_ff, rhi_s_ff, cs_ff;
   logic [DW-1:0] lo_d_ff, hi_d_ff, rlo_d_ff, rhi_d_ff, cd_ff;
   logic [TW-1:0] lo_t_ff, hi_t_ff, rhi_t_ff, ct_ff;
   side_type      side_ff;
   logic [6:0]    i_ff;
   logic [4:0]    flag_ff;
   kind_type      kind_ff;
   logic          occ_ff;
   logic [6:0]    su_ff, sl_ff;
   logic          free_ff;
   logic          rsp_valid_ff;

   logic [SW-1:0] a_s, b_s, min_s, max_s, nxt_s;
   logic [DW-1:0] a_d, b_d, min_d, max_d, nxt_d;
   logic [TW-1:0] a_t, b_t, min_t, max_t, nxt_t;
   logic [AW-1:0]   addr;
   logic [DAW-1:0]  word_addr;
   logic [LOGW-1:0] bit_sel;
   logic [6:0]      steps;
   logic            hit_su, hit_sl;
   logic            at_edge;

   // seeds saturate to the last cell of each axis
   assign a_s = (32'(req_first_s)  >= 32'(GRID_S)) ? S_MAX : SW'(req_first_s);
   assign b_s = (32'(req_second_s) >= 32'(GRID_S)) ? S_MAX : SW'(req_second_s);
   assign a_d = (32'(req_first_d)  >= 32'(GRID_D)) ? D_MAX : DW'(req_first_d);
   assign b_d = (32'(req_second_d) >= 32'(GRID_D)) ? D_MAX : DW'(req_second_d);
   assign a_t = (32'(req_first_t)  >= 32'(GRID_T)) ? T_MAX : TW'(req_first_t);
   assign b_t = (32'(req_second_t) >= 32'(GRID_T)) ? T_MAX : TW'(req_second_t);
   assign min_s = (a_s < b_s) ? a_s : b_s;
   assign max_s = (a_s < b_s) ? b_s : a_s;
   assign min_d = (a_d < b_d) ? a_d : b_d;
   assign max_d = (a_d < b_d) ? b_d : a_d;
   assign min_t = (a_t < b_t) ? a_t : b_t;
   assign max_t = (a_t < b_t) ? b_t : a_t;

   assign addr      = {ct_ff, cd_ff, cs_ff};
   assign word_addr = addr[AW-1:LOGW];
   assign bit_sel   = addr[LOGW-1:0];

   always_comb begin
      wr_word          = rd_ff;
      wr_word[bit_sel] = occ_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_ff] <= '0;
      end else if (cmd.wr) begin
         mem[word_addr] <= wr_word;
      end
      if (cmd.rd) begin
         rd_ff <= mem[word_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign nxt_s = (side_ff == SIDE_S_POS) ? hi_s_ff + 1'b1 : lo_s_ff - 1'b1;
   assign nxt_d = (side_ff == SIDE_D_POS) ? hi_d_ff + 1'b1 : lo_d_ff - 1'b1;
   assign nxt_t = hi_t_ff + 1'b1;

   always_comb begin
      case (side_ff)
         SIDE_S_POS: steps = cfg.s_pos_steps;
         SIDE_S_NEG: steps = cfg.s_neg_steps;
         SIDE_D_POS: steps = 7'(cfg.d_pos_steps);
         SIDE_D_NEG: steps = 7'(cfg.d_neg_steps);
         SIDE_T_POS: steps = 7'(cfg.t_pos_steps);
         default:    steps = 7'd0;
      endcase
   end

   always_comb begin
      case (side_ff)
         SIDE_S_POS: at_edge = (hi_s_ff == S_MAX);
         SIDE_S_NEG: at_edge = (lo_s_ff == '0);
         SIDE_D_POS: at_edge = (hi_d_ff == D_MAX);
         SIDE_D_NEG: at_edge = (lo_d_ff == '0);
         SIDE_T_POS: at_edge = (hi_t_ff == T_MAX);
         default:    at_edge = 1'b1;
      endcase
   end

   assign hit_su = 32'(hi_s_ff) >= 32'(su_ff);
   assign hit_sl = 32'(lo_s_ff) <= 32'(sl_ff);

   assign st.req_wr_ok  = (32'(req_first_s) < 32'(GRID_S)) &&
                          (32'(req_first_d) < 32'(GRID_D)) &&
                          (32'(req_first_t) < 32'(GRID_T));
   assign st.busy       = rd_ff[bit_sel];
   assign st.scan_last  = (cs_ff == rhi_s_ff) && (cd_ff == rhi_d_ff) && (ct_ff == rhi_t_ff);
   assign st.side_skip  = (side_ff != SIDE_T_POS) && flag_ff[side_ff];
   assign st.steps_zero = (steps == 7'd0);
   assign st.steps_used = (i_ff == steps);
   assign st.at_edge    = at_edge;
   assign st.side       = side_ff;
   assign st.round_all  = flag_ff[3] & flag_ff[2] & (flag_ff[1] | hit_sl) & (flag_ff[0] | hit_su);
   assign st.t_flag     = flag_ff[4];
   assign st.span_full  = (32'(hi_t_ff) - 32'(lo_t_ff)) >= 32'(cfg.max_time_span);
   assign st.clear_last = &clr_ff;
   assign st.out_blocked = rsp_valid_ff & rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_type'(req_kind);
         occ_ff   <= req_cell_occupied;
         su_ff    <= req_s_upper_limit;
         sl_ff    <= req_s_lower_limit;
         free_ff  <= 1'b1;
         lo_s_ff  <= min_s;
         hi_s_ff  <= max_s;
         lo_d_ff  <= min_d;
         hi_d_ff  <= max_d;
         lo_t_ff  <= min_t;
         hi_t_ff  <= max_t;
         rlo_s_ff <= min_s;
         rhi_s_ff <= max_s;
         rlo_d_ff <= min_d;
         rhi_d_ff <= max_d;
         rhi_t_ff <= max_t;
         side_ff  <= SIDE_S_POS;
         i_ff     <= 7'd0;
         flag_ff  <= 5'd0;
         if (kind_type'(req_kind) == KIND_WRITE) begin
            cs_ff <= a_s;
            cd_ff <= a_d;
            ct_ff <= a_t;
         end else begin
            cs_ff <= min_s;
            cd_ff <= min_d;
            ct_ff <= min_t;
         end
      end
      if (cmd.fail) begin
         free_ff <= 1'b0;
      end
      if (cmd.step) begin
         if (cs_ff != rhi_s_ff) begin
            cs_ff <= cs_ff + 1'b1;
         end else begin
            cs_ff <= rlo_s_ff;
            if (cd_ff != rhi_d_ff) begin
               cd_ff <= cd_ff + 1'b1;
            end else begin
               cd_ff <= rlo_d_ff;
               ct_ff <= ct_ff + 1'b1;
            end
         end
      end
      // scan region is the cube with the grown axis pinned to the next plane
      if (cmd.setup) begin
         rlo_s_ff <= lo_s_ff;
         rhi_s_ff <= hi_s_ff;
         rlo_d_ff <= lo_d_ff;
         rhi_d_ff <= hi_d_ff;
         rhi_t_ff <= hi_t_ff;
         cs_ff    <= lo_s_ff;
         cd_ff    <= lo_d_ff;
         ct_ff    <= lo_t_ff;
         case (side_ff)
            SIDE_S_POS, SIDE_S_NEG: begin
               rlo_s_ff <= nxt_s;
               rhi_s_ff <= nxt_s;
               cs_ff    <= nxt_s;
            end
            SIDE_D_POS, SIDE_D_NEG: begin
               rlo_d_ff <= nxt_d;
               rhi_d_ff <= nxt_d;
               cd_ff    <= nxt_d;
            end
            SIDE_T_POS: begin
               rhi_t_ff <= nxt_t;
               ct_ff    <= nxt_t;
            end
            default: ;
         endcase
      end
      if (cmd.accept) begin
         i_ff <= i_ff + 1'b1;
         case (side_ff)
            SIDE_S_POS: hi_s_ff <= nxt_s;
            SIDE_S_NEG: lo_s_ff <= nxt_s;
            SIDE_D_POS: hi_d_ff <= nxt_d;
            SIDE_D_NEG: lo_d_ff <= nxt_d;
            SIDE_T_POS: hi_t_ff <= nxt_t;
            default: ;
         endcase
      end
      if (cmd.done) begin
         flag_ff[side_ff] <= 1'b1;
      end
      if (cmd.next_side) begin
         i_ff <= 7'd0;
         if (side_ff == SIDE_S_POS || side_ff == SIDE_S_NEG || side_ff == SIDE_D_POS) begin
            side_ff <= side_type'(side_ff + 3'd1);
         end
      end
      if (cmd.round_end) begin
         i_ff <= 7'd0;
         if (hit_su) flag_ff[0] <= 1'b1;
         if (hit_sl) flag_ff[1] <= 1'b1;
         side_ff <= st.round_all ? SIDE_T_POS : SIDE_S_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         if (kind_ff == KIND_INFLATE) begin
            rsp_initial_free <= free_ff;
            rsp_low_s        <= 7'(lo_s_ff);
            rsp_high_s       <= 7'(hi_s_ff);
            rsp_low_d        <= 5'(lo_d_ff);
            rsp_high_d       <= 5'(hi_d_ff);
            rsp_low_t        <= 6'(lo_t_ff);
            rsp_high_t       <= 6'(hi_t_ff);
         end else begin
            rsp_initial_free <= 1'b1;
            rsp_low_s        <= 7'd0;
            rsp_high_s       <= 7'd0;
            rsp_low_d        <= 5'd0;
            rsp_high_d       <= 5'd0;
            rsp_low_t        <= 6'd0;
            rsp_high_t       <= 6'd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/occupancy_cube_inflation.sv
// ----------------------------------------------------------------------------
// occupancy_cube_inflation: 3D occupancy map with free-cube growth
// Keeps an (s, d, t) occupancy bitmap and grows free cubes from seed cells.
// ----------------------------------------------------------------------------
// Each request word gives one result word. The map is a memory of 32-bit
// words addressed by the concatenated (t, d, s) cell index; every cell test
// is a read, then a check, one cell at a time through that single memory
// port. A cell write is a read-modify-write. A grid clear, and the clearing
// pass right after reset, sweep one memory word per cycle over all
// 2^(clog2 S + clog2 D + clog2 T - 5) words, 8192 for the default grid; no
// request word is taken during the pass. An inflate reads and checks each
// cell of the seed cube, then of each plane tried, up to an occupied cell.
// The result sits in an output register, so the next request word is taken
// while it waits. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module occupancy_cube_inflation
   import occ_pkg::*;
#(
   parameter int GRID_S = 128,
   parameter int GRID_D = 32,
   parameter int GRID_T = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [6:0]  req_first_s,
   input  logic [4:0]  req_first_d,
   input  logic [5:0]  req_first_t,
   input  logic        req_cell_occupied,
   input  logic [6:0]  req_second_s,
   input  logic [4:0]  req_second_d,
   input  logic [5:0]  req_second_t,
   input  logic [6:0]  req_s_upper_limit,
   input  logic [6:0]  req_s_lower_limit,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_initial_free,
   output logic [6:0]  rsp_low_s,
   output logic [6:0]  rsp_high_s,
   output logic [4:0]  rsp_low_d,
   output logic [4:0]  rsp_high_d,
   output logic [5:0]  rsp_low_t,
   output logic [5:0]  rsp_high_t,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type st;

   // step counts and time span limit
   occ_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequence: clear pass, writes, seed check, s and d rounds, then time growth
   occ_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .st        (st),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // map memory, cube bounds, scan position and output register
   occ_dp #(
      .GRID_S (GRID_S),
      .GRID_D (GRID_D),
      .GRID_T (GRID_T)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .req_kind          (req_kind),
      .req_first_s       (req_first_s),
      .req_first_d       (req_first_d),
      .req_first_t       (req_first_t),
      .req_cell_occupied (req_cell_occupied),
      .req_second_s      (req_second_s),
      .req_second_d      (req_second_d),
      .req_second_t      (req_second_t),
      .req_s_upper_limit (req_s_upper_limit),
      .req_s_lower_limit (req_s_lower_limit),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_initial_free  (rsp_initial_free),
      .rsp_low_s         (rsp_low_s),
      .rsp_high_s        (rsp_high_s),
      .rsp_low_d         (rsp_low_d),
      .rsp_high_d        (rsp_high_d),
      .rsp_low_t         (rsp_low_t),
      .rsp_high_t        (rsp_high_t),
      .st                (st)
   );

endmodule

### tb/occupancy_cube_inflation_tb.sv
// ----------------------------------------------------------------------------
// occupancy_cube_inflation_tb: self-checking bench for cube inflation
// Drives request words through a valid/stall channel, keeps its own copy of
// the occupancy map and the step registers, predicts every result word and
// compares it field by field. Phases change the registers over the APB port
// and the idling pattern on both channels.
// ----------------------------------------------------------------------------
module occupancy_cube_inflation_tb
   import occ_pkg::*;
();

   localparam int CELLS        = 128 * 32 * 64;
   localparam int IDLE_LIMIT   = 400000;  // longest inflate plus a grid clear, with margin
   localparam int HOLD_CYCLES  = 3000;    // long receiver hold-off in the pressure phase
   localparam int SETTLE       = 20;

   typedef enum int {MODE_NONE, MODE_SEND, MODE_RECV, MODE_BOTH} idle_mode_type;

   typedef struct {
      kind_type   kind;
      logic [6:0] first_s;
      logic [4:0] first_d;
      logic [5:0] first_t;
      logic       occupied;
      logic [6:0] second_s;
      logic [4:0] second_d;
      logic [5:0] second_t;
      logic [6:0] s_up;
      logic [6:0] s_low;
   } word_type;

   typedef struct {
      logic       free;
      logic [6:0] low_s;
      logic [6:0] high_s;
      logic [4:0] low_d;
      logic [4:0] high_d;
      logic [5:0] low_t;
      logic [5:0] high_t;
   } cube_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [6:0]  req_first_s = '0;
   logic [4:0]  req_first_d = '0;
   logic [5:0]  req_first_t = '0;
   logic        req_cell_occupied = 1'b0;
   logic [6:0]  req_second_s = '0;
   logic [4:0]  req_second_d = '0;
   logic [5:0]  req_second_t = '0;
   logic [6:0]  req_s_upper_limit = '0;
   logic [6:0]  req_s_lower_limit = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_initial_free;
   logic [6:0]  rsp_low_s, rsp_high_s;
   logic [4:0]  rsp_low_d, rsp_high_d;
   logic [5:0]  rsp_low_t, rsp_high_t;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   occupancy_cube_inflation u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the block
   bit            occ_map [CELLS];
   int            cfg_now [6] = '{1, 1, 1, 1, 1, 8};
   int            axis_len [3] = '{128, 32, 64};
   int            bnd_lo [3];
   int            bnd_hi [3];

   word_type      req_backlog_q [$];
   cube_type      cube_expect_q [$];
   idle_mode_type idle_mode = MODE_NONE;
   bit            pressure_on = 1'b0;
   bit            hold_used = 1'b0;
   int            hold_left = 0;
   int            fail_count = 0;
   int            idle_cycles = 0;

   function automatic int cell_at(int s, int d, int t);
      return (t * 32 + d) * 128 + s;
   endfunction

   function automatic bit region_free(int lo[3], int hi[3]);
      for (int s = lo[0]; s <= hi[0]; s++)
         for (int d = lo[1]; d <= hi[1]; d++)
            for (int t = lo[2]; t <= hi[2]; t++)
               if (occ_map[cell_at(s, d, t)]) return 1'b0;
      return 1'b1;
   endfunction

   // Push one side out by up to steps planes; return 1 once the side is finished.
   function automatic bit grow_face(int ax, bit up, int steps);
      int nxt;
      int a [3];
      int b [3];
      if (steps == 0) return 1'b1;
      for (int i = 0; i < steps; i++) begin
         nxt = up ? bnd_hi[ax] + 1 : bnd_lo[ax] - 1;
         if (nxt < 0 || nxt >= axis_len[ax]) return 1'b1;
         a = bnd_lo;
         b = bnd_hi;
         a[ax] = nxt;
         b[ax] = nxt;
         if (!region_free(a, b)) return 1'b1;
         if (up) bnd_hi[ax] = nxt;
         else bnd_lo[ax] = nxt;
      end
      return 1'b0;
   endfunction

   // Apply one word to the shadow map and return the cube it should produce.
   function automatic cube_type inflate_cube(word_type w);
      cube_type r;
      int sa [3];
      int sb [3];
      bit sp, sn, dp, dn, tp;
      r = '{1'b1, 0, 0, 0, 0, 0, 0};
      case (w.kind)
         KIND_WRITE: begin
            occ_map[cell_at(w.first_s, w.first_d, w.first_t)] = w.occupied;
            return r;
         end
         KIND_CLEAR: begin
            foreach (occ_map[i]) occ_map[i] = 1'b0;
            return r;
         end
         KIND_INFLATE: ;
         default: return r;
      endcase
      sa = '{int'(w.first_s), int'(w.first_d), int'(w.first_t)};
      sb = '{int'(w.second_s), int'(w.second_d), int'(w.second_t)};
      for (int i = 0; i < 3; i++) begin
         bnd_lo[i] = sa[i] < sb[i] ? sa[i] : sb[i];
         bnd_hi[i] = sa[i] < sb[i] ? sb[i] : sa[i];
      end
      if (!region_free(bnd_lo, bnd_hi)) begin
         r.free = 1'b0;
      end else begin
         {sp, sn, dp, dn, tp} = '0;
         while (!(sp && sn && dp && dn)) begin
            if (!sp) sp = grow_face(0, 1'b1, cfg_now[REG_S_POS_STEPS]);
            if (!sn) sn = grow_face(0, 1'b0, cfg_now[REG_S_NEG_STEPS]);
            if (!dp) dp = grow_face(1, 1'b1, cfg_now[REG_D_POS_STEPS]);
            if (!dn) dn = grow_face(1, 1'b0, cfg_now[REG_D_NEG_STEPS]);
            // s limits only count at the end of a whole round
            if (bnd_hi[0] >= int'(w.s_up)) sp = 1'b1;
            if (bnd_lo[0] <= int'(w.s_low)) sn = 1'b1;
         end
         while (!tp) begin
            tp = grow_face(2, 1'b1, cfg_now[REG_T_POS_STEPS]);
            if (bnd_hi[2] - bnd_lo[2] >= cfg_now[REG_MAX_TIME_SPAN]) tp = 1'b1;
         end
      end
      r.low_s  = 7'(bnd_lo[0]);
      r.high_s = 7'(bnd_hi[0]);
      r.low_d  = 5'(bnd_lo[1]);
      r.high_d = 5'(bnd_hi[1]);
      r.low_t  = 6'(bnd_lo[2]);
      r.high_t = 6'(bnd_hi[2]);
      return r;
   endfunction

   // Request driver: hold a word until taken, then offer the next one or idle.
   always @(posedge clock) begin
      word_type w;
      bit       taken;
      bit       offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            w.kind     = kind_type'(req_kind);
            w.first_s  = req_first_s;
            w.first_d  = req_first_d;
            w.first_t  = req_first_t;
            w.occupied = req_cell_occupied;
            w.second_s = req_second_s;
            w.second_d = req_second_d;
            w.second_t = req_second_t;
            w.s_up     = req_s_upper_limit;
            w.s_low    = req_s_lower_limit;
            cube_expect_q.insert(cube_expect_q.size(), inflate_cube(w));
         end
         if (!req_valid || taken) begin
            offer = req_backlog_q.size() != 0;
            if (idle_mode == MODE_SEND && $urandom_range(0, 99) < 45) offer = 1'b0;
            if (idle_mode == MODE_BOTH && $urandom_range(0, 99) < 12) offer = 1'b0;
            if (offer) begin
               w = req_backlog_q.pop_front();
               req_kind          <= w.kind;
               req_first_s       <= w.first_s;
               req_first_d       <= w.first_d;
               req_first_t       <= w.first_t;
               req_cell_occupied <= w.occupied;
               req_second_s      <= w.second_s;
               req_second_d      <= w.second_d;
               req_second_t      <= w.second_t;
               req_s_upper_limit <= w.s_up;
               req_s_lower_limit <= w.s_low;
            end
            req_valid <= offer;
         end
      end
   end

   // Long hold-off: count it down here, once, when the pressure phase starts.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (pressure_on && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Result monitor: check each taken word against the oldest prediction.
   always @(posedge clock) begin
      cube_type c;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cube_expect_q.size() == 0) begin
               $display("%0t: result word with nothing expected", $time);
               fail_count++;
            end else begin
               c = cube_expect_q.pop_front();
               check_field("initial_free", c.free, rsp_initial_free);
               check_field("low_s", c.low_s, rsp_low_s);
               check_field("high_s", c.high_s, rsp_high_s);
               check_field("low_d", c.low_d, rsp_low_d);
               check_field("high_d", c.high_d, rsp_high_d);
               check_field("low_t", c.low_t, rsp_low_t);
               check_field("high_t", c.high_t, rsp_high_t);
            end
         end
         if (hold_left > 0)
            rsp_stall <= 1'b1;
         else if (idle_mode == MODE_RECV)
            rsp_stall <= $urandom_range(0, 99) < 45;
         else if (idle_mode == MODE_BOTH)
            rsp_stall <= $urandom_range(0, 99) < 12;
         else
            rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("occupancy_cube_inflation test failed");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, int val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(idx) << 2;
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_now[idx] = val;
   endtask

   task automatic load_steps(int sp, int sn, int dp, int dn, int tp, int span);
      csr_write(REG_S_POS_STEPS, sp);
      csr_write(REG_S_NEG_STEPS, sn);
      csr_write(REG_D_POS_STEPS, dp);
      csr_write(REG_D_NEG_STEPS, dn);
      csr_write(REG_T_POS_STEPS, tp);
      csr_write(REG_MAX_TIME_SPAN, span);
   endtask

   task automatic queue_word(kind_type k, int fs, int fd, int ft, bit occ,
                             int ss, int sd, int st, int up, int low);
      word_type w;
      w = '{k, fs, fd, ft, occ, ss, sd, st, up, low};
      req_backlog_q.insert(req_backlog_q.size(), w);
   endtask

   function automatic int clip(int v, int top);
      return v < 0 ? 0 : (v > top ? top : v);
   endfunction

   function automatic int jitter(int c, int r, int top);
      return clip(c + $urandom_range(0, 2 * r) - r, top);
   endfunction

   // Random words clustered around a wandering focus cell so that obstacles
   // and seeds meet; s limits mostly close to the seed to bound the cube.
   task automatic queue_random(int n);
      int fs, fd, ft, roll, s1, d1, t1, up, low;
      for (int k = 0; k < n; k++) begin
         if (k % 10 == 0) begin
            fs = $urandom_range(0, 127);
            fd = $urandom_range(0, 31);
            ft = $urandom_range(0, 63);
         end
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            queue_word(KIND_WRITE, jitter(fs, 3, 127), jitter(fd, 3, 31), jitter(ft, 3, 63),
                       $urandom_range(0, 99) < 80, $urandom_range(0, 127),
                       $urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 127), $urandom_range(0, 127));
         end else if (roll < 42) begin
            queue_word(KIND_CLEAR, $urandom_range(0, 127), $urandom_range(0, 31),
                       $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 127),
                       $urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 127), $urandom_range(0, 127));
         end else if (roll < 45) begin
            queue_word(KIND_NONE, $urandom_range(0, 127), $urandom_range(0, 31),
                       $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 127),
                       $urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 127), $urandom_range(0, 127));
         end else begin
            s1 = jitter(fs, 2, 127);
            d1 = jitter(fd, 2, 31);
            t1 = jitter(ft, 2, 63);
            if ($urandom_range(0, 99) < 92) begin
               up  = clip(s1 + $urandom_range(0, 4), 127);
               low = clip(s1 - $urandom_range(0, 4), 127);
            end else begin
               up  = $urandom_range(0, 127);
               low = $urandom_range(0, 127);
            end
            queue_word(KIND_INFLATE, s1, d1, t1, $urandom_range(0, 1),
                       jitter(s1, 2, 127), jitter(d1, 2, 31), jitter(t1, 2, 63), up, low);
         end
      end
   endtask

   // Hold until every word is taken and answered, then let the block settle.
   task automatic drain;
      do @(negedge clock);
      while (req_backlog_q.size() != 0 || req_valid || cube_expect_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at the reset settings
      queue_word(KIND_WRITE, 5, 5, 5, 1, 0, 0, 0, 0, 0);
      queue_word(KIND_INFLATE, 5, 5, 5, 0, 5, 5, 5, 7, 3);       // seed on an occupied cell
      queue_word(KIND_INFLATE, 7, 4, 6, 0, 3, 6, 4, 9, 1);       // occupied cell inside the seed cube
      queue_word(KIND_WRITE, 5, 5, 5, 0, 0, 0, 0, 0, 0);
      queue_word(KIND_INFLATE, 12, 6, 3, 0, 10, 4, 2, 14, 8);    // second seed below the first
      queue_word(KIND_NONE, 127, 31, 63, 1, 127, 31, 63, 127, 127);
      queue_word(KIND_WRITE, 0, 0, 0, 1, 127, 31, 63, 127, 127);
      queue_word(KIND_WRITE, 127, 31, 63, 1, 0, 0, 0, 0, 0);
      queue_word(KIND_INFLATE, 0, 0, 0, 1, 0, 0, 0, 0, 0);       // corner, blocked
      queue_word(KIND_INFLATE, 127, 0, 63, 0, 0, 31, 63, 127, 0); // full s by d face, blocked
      queue_word(KIND_WRITE, 127, 31, 63, 0, 0, 0, 0, 0, 0);
      queue_word(KIND_INFLATE, 127, 31, 63, 0, 127, 31, 63, 127, 127);
      queue_word(KIND_INFLATE, 0, 31, 0, 0, 0, 31, 0, 0, 0);     // both limits met at once
      queue_word(KIND_INFLATE, 60, 10, 10, 0, 61, 11, 10, 0, 127); // limits crossed
      queue_word(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      queue_word(KIND_INFLATE, 0, 0, 0, 0, 1, 1, 1, 2, 0);
      queue_word(KIND_INFLATE, 64, 16, 32, 1, 64, 16, 32, 66, 62);
      drain();

      load_steps(3, 3, 2, 2, 2, 3);
      idle_mode = MODE_SEND;
      queue_random(90);
      drain();

      // Widest steps: sides run to the edge in one round; no time span
      idle_mode = MODE_NONE;
      load_steps(127, 127, 31, 31, 1, 0);
      queue_random(10);
      drain();

      // Zero steps on every s and d side; longest time growth
      load_steps(0, 0, 0, 0, 63, 63);
      idle_mode = MODE_BOTH;
      queue_random(40);
      drain();

      // Receiver holds off long while the sender keeps offering words
      idle_mode = MODE_RECV;
      load_steps(2, 4, 1, 3, 5, 0);
      @(negedge clock);
      pressure_on = 1'b1;
      queue_random(90);
      drain();

      load_steps(1, 2, 31, 1, 2, 4);
      idle_mode = MODE_BOTH;
      queue_random(70);
      drain();

      if (fail_count == 0 && cube_expect_q.size() == 0)
         $display("occupancy_cube_inflation test passed");
      else
         $display("occupancy_cube_inflation test failed");
      $finish;
   end

endmodule

### sim.f
rtl/occ_pkg.sv
rtl/occ_csr.sv
rtl/occ_ctrl.sv
rtl/occ_dp.sv
rtl/occupancy_cube_inflation.sv
tb/occupancy_cube_inflation_tb.sv
